// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop)

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/mlk_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlk_pkg
// Shared types, constants and the letter lookup for the Morse LED keyer.
// ---------------------------------------------------------------------------
package mlk_pkg;

	localparam int MAX_LETTERS_DEF = 32;
	localparam int TIME_W          = 16;
	localparam int CODE_W          = 5;
	localparam int LEN_W           = 6;
	localparam int LIDX_W          = 6;
	localparam int CNT_W           = 3;
	localparam int EIDX_W          = 2;
	localparam int SYM_W           = 6;
	localparam int CFG_IDX_W       = 3;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_DOT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DASH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;

	localparam logic [TIME_W-1:0] DOT_RST    = 16'd200;
	localparam logic [TIME_W-1:0] DASH_RST   = 16'd600;
	localparam logic [TIME_W-1:0] GAP_RST    = 16'd200;
	localparam logic [TIME_W-1:0] REPEAT_RST = 16'd1400;
	localparam logic [LEN_W-1:0]  LENGTH_RST = 6'd1;

	localparam logic          ACT_TICK  = 1'b0;
	localparam logic          ACT_WRITE = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] dot_time;
		logic [TIME_W-1:0] dash_time;
		logic [TIME_W-1:0] gap_time;
		logic [TIME_W-1:0] repeat_time;
		logic [LEN_W-1:0]  message_length;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [CODE_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic              led_lit;
		logic              repeat_pending;
		logic [CNT_W-1:0]  element_count;
		logic [EIDX_W-1:0] element_index;
	} seq_status_t;

	// marker bit (16/8/4/2) sets element count, bits below it: 1 = dash
	function automatic logic [SYM_W-1:0] morse_symbol(input logic [CODE_W-1:0] code);
		logic [SYM_W-1:0] sym;
		unique case (code)
			5'd0:    sym = 6'd37;
			5'd1:    sym = 6'd56;
			5'd2:    sym = 6'd58;
			5'd3:    sym = 6'd44;
			5'd4:    sym = 6'd34;
			5'd5:    sym = 6'd50;
			5'd6:    sym = 6'd46;
			5'd7:    sym = 6'd48;
			5'd8:    sym = 6'd36;
			5'd9:    sym = 6'd55;
			5'd10:   sym = 6'd45;
			5'd11:   sym = 6'd52;
			5'd12:   sym = 6'd39;
			5'd13:   sym = 6'd38;
			5'd14:   sym = 6'd47;
			5'd15:   sym = 6'd54;
			5'd16:   sym = 6'd61;
			5'd17:   sym = 6'd42;
			5'd18:   sym = 6'd40;
			5'd19:   sym = 6'd35;
			5'd20:   sym = 6'd41;
			default: sym = 6'd34;
		endcase
		return sym;
	endfunction

endpackage

// ===== src/mlk_cfg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlk_cfg
// Timing and length registers, written through the configuration channel.
// ---------------------------------------------------------------------------
module mlk_cfg import mlk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_time       <= DOT_RST;
			cfg_q.dash_time      <= DASH_RST;
			cfg_q.gap_time       <= GAP_RST;
			cfg_q.repeat_time    <= REPEAT_RST;
			cfg_q.message_length <= LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DOT:    cfg_q.dot_time       <= cfg_data;
				REG_DASH:   cfg_q.dash_time      <= cfg_data;
				REG_GAP:    cfg_q.gap_time       <= cfg_data;
				REG_REPEAT: cfg_q.repeat_time    <= cfg_data;
				REG_LENGTH: cfg_q.message_length <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== src/mlk_msg_mem.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlk_msg_mem
// Message store: one write port, one registered read port, with a bypass
// for a write to the slot being read in the same cycle.
// ---------------------------------------------------------------------------
module mlk_msg_mem import mlk_pkg::*; #(
	parameter int MAX_LETTERS = MAX_LETTERS_DEF,
	parameter int AW          = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_wr_t           wr,
	input  logic [AW-1:0]     wr_addr,
	input  logic [AW-1:0]     rd_addr,
	output logic [CODE_W-1:0] rd_data
);

	logic [CODE_W-1:0] msg_mem_q [MAX_LETTERS];
	logic [CODE_W-1:0] rd_data_q;
	logic [CODE_W-1:0] byp_data_q;
	logic              byp_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			msg_mem_q[wr_addr] <= wr.data;
		end
		rd_data_q  <= msg_mem_q[rd_addr];
		byp_data_q <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= wr.en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_data_q;

endmodule

// ===== src/mlk_seq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlk_seq
// Keyer sequencer: element and letter timing, message write requests and
// the result register. Reads the next letter slot every cycle.
// ---------------------------------------------------------------------------
module mlk_seq import mlk_pkg::*; #(
	parameter int MAX_LETTERS = MAX_LETTERS_DEF,
	parameter int AW          = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              action,
	input  logic [CODE_W-1:0] letter_code,
	input  logic [4:0]        write_position,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              led,
	output logic [4:0]        letter_position,
	output logic [1:0]        element_position,
	output logic              in_repeat_pause,
	input  cfg_t              cfg,
	input  logic [CODE_W-1:0] rd_code,
	output mem_wr_t           wr,
	output logic [AW-1:0]     wr_addr,
	output logic [AW-1:0]     rd_addr,
	output seq_status_t       status
);

	logic              led_q;
	logic              pend_q;
	logic [EIDX_W-1:0] eidx_q;
	logic [CNT_W-1:0]  ecnt_q;
	logic [LIDX_W-1:0] lidx_q;
	logic [TIME_W-1:0] elapsed_q;
	logic              result_valid_q;

	logic              led_d;
	logic              pend_d;
	logic [EIDX_W-1:0] eidx_d;
	logic [CNT_W-1:0]  ecnt_d;
	logic [LIDX_W-1:0] lidx_d;
	logic [TIME_W-1:0] elapsed_d;

	logic              accept;
	logic              tick;
	logic [SYM_W-1:0]  sym;
	logic [TIME_W-1:0] el_inc;
	logic [CNT_W-1:0]  sh_full;
	logic              is_dash;
	logic [CNT_W-1:0]  eidx_nx;
	logic [LIDX_W-1:0] lidx_nx;
	logic [LEN_W-1:0]  eff_len;
	logic [LIDX_W+AW-1:0] rd_ext;
	logic [5+AW-1:0]      wr_ext;

	assign item_stall = result_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;
	assign tick       = accept && (action == ACT_TICK);

	assign sym     = morse_symbol(rd_code);
	assign el_inc  = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign sh_full = ecnt_q - 1'b1 - {1'b0, eidx_q};
	assign is_dash = (ecnt_q > {1'b0, eidx_q}) ? sym[sh_full[1:0]] : 1'b0;
	assign eidx_nx = {1'b0, eidx_q} + 1'b1;
	assign lidx_nx = lidx_q + 1'b1;

	always_comb begin
		if (cfg.message_length == '0) begin
			eff_len = LEN_W'(1);
		end else if (32'(cfg.message_length) > MAX_LETTERS) begin
			eff_len = LEN_W'(MAX_LETTERS);
		end else begin
			eff_len = cfg.message_length;
		end
	end

	always_comb begin
		led_d     = led_q;
		pend_d    = pend_q;
		eidx_d    = eidx_q;
		ecnt_d    = ecnt_q;
		lidx_d    = lidx_q;
		elapsed_d = elapsed_q;
		if (tick) begin
			elapsed_d = el_inc;
			if (led_q) begin
				if (el_inc > (is_dash ? cfg.dash_time : cfg.dot_time)) begin
					led_d     = 1'b0;
					elapsed_d = '0;
					if (eidx_nx >= ecnt_q) begin
						ecnt_d = '0;
						eidx_d = '0;
						if (lidx_nx >= LIDX_W'(eff_len)) begin
							lidx_d = '0;
							pend_d = 1'b1;
						end else begin
							lidx_d = lidx_nx;
						end
					end else begin
						eidx_d = eidx_nx[EIDX_W-1:0];
					end
				end
			end else if (pend_q) begin
				if (el_inc > cfg.repeat_time) begin
					pend_d = 1'b0;
				end
			end else if (el_inc > cfg.gap_time) begin
				if (ecnt_q == '0) begin
					if (sym[4]) begin
						ecnt_d = CNT_W'(4);
					end else if (sym[3]) begin
						ecnt_d = CNT_W'(3);
					end else if (sym[2]) begin
						ecnt_d = CNT_W'(2);
					end else begin
						ecnt_d = CNT_W'(1);
					end
				end
				elapsed_d = '0;
				led_d     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q          <= 1'b0;
			pend_q         <= 1'b0;
			eidx_q         <= '0;
			ecnt_q         <= '0;
			lidx_q         <= '0;
			elapsed_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			led_q     <= led_d;
			pend_q    <= pend_d;
			eidx_q    <= eidx_d;
			ecnt_q    <= ecnt_d;
			lidx_q    <= lidx_d;
			elapsed_q <= elapsed_d;
			if (accept) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// read slot of the letter current after this cycle
	assign rd_ext  = {{AW{1'b0}}, lidx_d};
	assign rd_addr = rd_ext[AW-1:0];

	assign wr_ext  = {{AW{1'b0}}, write_position};
	assign wr_addr = wr_ext[AW-1:0];
	assign wr.en   = accept && (action == ACT_WRITE) && (32'(write_position) < MAX_LETTERS);
	assign wr.data = letter_code;

	assign result_valid     = result_valid_q;
	assign led              = led_q;
	assign letter_position  = lidx_q[4:0];
	assign element_position = eidx_q;
	assign in_repeat_pause  = pend_q;

	assign status.led_lit        = led_q;
	assign status.repeat_pending = pend_q;
	assign status.element_count  = ecnt_q;
	assign status.element_index  = eidx_q;

endmodule

// ===== src/morse_led_keyer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// morse_led_keyer_unit
// Sends a stored message in Morse code on one LED, one tick item per ms.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  item     | item_valid, item_stall  | action, letter_code, write_position
//  result   | result_valid,           | led, letter_position,
//           | result_stall            | element_position, in_repeat_pause
//  config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
//  One item per cycle unless stalled; result in the cycle after acceptance.
//  The letter slot for the next item is read from the message memory in
//  the cycle of the current one (registered read, write bypass).
//  Reset clears all control state; the message memory is not cleared.
//  An item is taken while the result register is empty or being drained.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module morse_led_keyer_unit import mlk_pkg::*; #(
	parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 action,
	input  logic [CODE_W-1:0]    letter_code,
	input  logic [4:0]           write_position,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 led,
	output logic [4:0]           letter_position,
	output logic [1:0]           element_position,
	output logic                 in_repeat_pause,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data
);

	localparam int AW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;

	cfg_t              cfg;
	mem_wr_t           wr;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [CODE_W-1:0] rd_code;
	seq_status_t       status;

	mlk_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mlk_msg_mem #(
		.MAX_LETTERS (MAX_LETTERS),
		.AW          (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.rd_data (rd_code)
	);

	mlk_seq #(
		.MAX_LETTERS (MAX_LETTERS),
		.AW          (AW)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.action           (action),
		.letter_code      (letter_code),
		.write_position   (write_position),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.led              (led),
		.letter_position  (letter_position),
		.element_position (element_position),
		.in_repeat_pause  (in_repeat_pause),
		.cfg              (cfg),
		.rd_code          (rd_code),
		.wr               (wr),
		.wr_addr          (wr_addr),
		.rd_addr          (rd_addr),
		.status           (status)
	);

	`ASSERT_HOLDS(a_eidx_in_letter, clk, arst_n, (status.element_count == '0) || ({1'b0, status.element_index} < status.element_count))
	`ASSERT_IMPLIES(a_lit_decoded, clk, arst_n, status.led_lit, (status.element_count != '0) && !status.repeat_pending)
	`ASSERT_IMPLIES(a_pause_idle, clk, arst_n, status.repeat_pending, !status.led_lit && (status.element_count == '0) && (status.element_index == '0))
	`ASSERT_IMPLIES(a_result_follows, clk, arst_n, $past(item_valid && !item_stall), result_valid)

endmodule

// ===== dv/tb_morse_led_keyer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_morse_led_keyer_unit
// Self-checking bench: keying predictor, random ticks and writes, stalls.
// ---------------------------------------------------------------------------
//  A keying predictor runs alongside the block and compares every result
//  item with its own expectation. The message is written in full before
//  any tick. A short directed run is followed by randomised phases under
//  three idling regimes: sender light and receiver heavy, the reverse, and
//  none. Each phase starts with new register values. One phase holds all
//  times near their maximum so that no element or gap ends during it.
// ---------------------------------------------------------------------------
module tb_morse_led_keyer_unit;
	import mlk_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int HOLD_CYCLES = 150;

	localparam bit [5:0] SYMBOL_ROM [0:31] = '{
		6'd37, 6'd56, 6'd58, 6'd44, 6'd34, 6'd50, 6'd46, 6'd48,
		6'd36, 6'd55, 6'd45, 6'd52, 6'd39, 6'd38, 6'd47, 6'd54,
		6'd61, 6'd42, 6'd40, 6'd35, 6'd41, 6'd34, 6'd34, 6'd34,
		6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34
	};

	typedef struct packed {
		logic       led;
		logic [4:0] letter_position;
		logic [1:0] element_position;
		logic       in_repeat_pause;
	} keyer_out_t;

	class keyer_scoreboard;
		bit [15:0]  dot_t, dash_t, gap_t, rep_t;
		bit [5:0]   len_reg;
		bit         lit, rep_pend;
		int         eidx, count, lidx;
		bit [15:0]  elapsed;
		bit [4:0]   store [32];
		keyer_out_t expected_q[$];
		int         errors, ticks, writes, lit_seen, pause_seen;

		function new();
			dot_t   = DOT_RST;
			dash_t  = DASH_RST;
			gap_t   = GAP_RST;
			rep_t   = REPEAT_RST;
			len_reg = LENGTH_RST;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
			case (idx)
				REG_DOT:    dot_t   = data;
				REG_DASH:   dash_t  = data;
				REG_GAP:    gap_t   = data;
				REG_REPEAT: rep_t   = data;
				REG_LENGTH: len_reg = data[5:0];
				default: ;
			endcase
		endfunction

		function int msg_len();
			if (len_reg == 0)
				return 1;
			if (len_reg > MAX_LETTERS_DEF)
				return MAX_LETTERS_DEF;
			return int'(len_reg);
		endfunction

		function void end_element();
			int nxt;
			nxt = eidx + 1;
			lit = 1'b0;
			if (nxt >= count) begin
				lidx++;
				count = 0;
				if (lidx >= msg_len()) begin
					lidx = 0;
					rep_pend = 1'b1;
				end
				nxt = 0;
			end
			eidx = nxt & 3;
		endfunction

		function void advance_ms();
			bit [5:0] sym;
			bit       dash;
			sym = SYMBOL_ROM[store[lidx % MAX_LETTERS_DEF]];
			if (elapsed != 16'hFFFF)
				elapsed++;
			if (lit) begin
				dash = 1'b0;
				if (count > eidx)
					dash = sym[count - 1 - eidx];
				if (elapsed > (dash ? dash_t : dot_t)) begin
					end_element();
					elapsed = '0;
				end
			end else if (rep_pend) begin
				if (elapsed > rep_t)
					rep_pend = 1'b0;
			end else if (elapsed > gap_t) begin
				if (count == 0) begin
					if (sym[4])
						count = 4;
					else if (sym[3])
						count = 3;
					else if (sym[2])
						count = 2;
					else
						count = 1;
				end
				elapsed = '0;
				lit = 1'b1;
			end
		endfunction

		function void note_item(logic act, logic [4:0] code, logic [4:0] pos);
			keyer_out_t r;
			if (act == ACT_WRITE) begin
				store[pos] = code;
				writes++;
			end else begin
				advance_ms();
				ticks++;
			end
			r.led              = lit;
			r.letter_position  = lidx[4:0];
			r.element_position = eidx[1:0];
			r.in_repeat_pause  = rep_pend;
			expected_q.push_back(r);
		endfunction

		function void cmp_field(string name, logic [4:0] want, logic [4:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(keyer_out_t got);
			keyer_out_t want;
			if (expected_q.size() == 0) begin
				$error("result item with nothing outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			cmp_field("led", 5'(want.led), 5'(got.led));
			cmp_field("letter_position", want.letter_position, got.letter_position);
			cmp_field("element_position", 5'(want.element_position),
				5'(got.element_position));
			cmp_field("in_repeat_pause", 5'(want.in_repeat_pause),
				5'(got.in_repeat_pause));
			if (want.led)
				lit_seen++;
			if (want.in_repeat_pause)
				pause_seen++;
		endfunction

		function void check_empty();
			if (expected_q.size() != 0) begin
				$error("%0d result items never arrived", expected_q.size());
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic                 action = ACT_TICK;
	logic [CODE_W-1:0]    letter_code = '0;
	logic [4:0]           write_position = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 led;
	logic [4:0]           letter_position;
	logic [1:0]           element_position;
	logic                 in_repeat_pause;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0]    cfg_data = '0;

	keyer_scoreboard sb = new();
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cfg_count = 0;

	morse_led_keyer_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.action           (action),
		.letter_code      (letter_code),
		.write_position   (write_position),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.led              (led),
		.letter_position  (letter_position),
		.element_position (element_position),
		.in_repeat_pause  (in_repeat_pause),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result({led, letter_position, element_position, in_repeat_pause});
			if (item_valid && !item_stall)
				sb.note_item(action, letter_code, write_position);
		end
	end

	task automatic send_item(logic act, logic [4:0] code, logic [4:0] pos);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid     <= 1'b1;
		action         <= act;
		letter_code    <= code;
		write_position <= pos;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_item(ACT_TICK, 5'($urandom), 5'($urandom));
	endtask

	task automatic wait_results(int extra);
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.expected_q.size() != 0);
		repeat (extra)
			@(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
		cfg_count++;
		@(negedge clk);
	endtask

	// block must be idle on entry
	task automatic set_config(logic [15:0] dot, logic [15:0] dash, logic [15:0] gap,
			logic [15:0] rep, logic [15:0] len_word);
		cfg_write(REG_DOT, dot);
		cfg_write(REG_DASH, dash);
		cfg_write(REG_GAP, gap);
		cfg_write(REG_REPEAT, rep);
		cfg_write(REG_LENGTH, len_word);
		if ($urandom_range(3) == 0)
			cfg_write(REG_SPARE, 16'($urandom));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_config();
		logic [15:0] t [4];
		logic [5:0]  len;
		for (int k = 0; k < 4; k++) begin
			if ($urandom_range(9) == 0)
				t[k] = 16'($urandom);
			else
				t[k] = 16'($urandom_range(5));
		end
		case ($urandom_range(9))
			0:       len = 6'd0;
			1:       len = 6'($urandom_range(63, 32));
			default: len = 6'($urandom_range(6, 1));
		endcase
		set_config(t[0], t[1], t[2], t[3], {10'($urandom), len});
	endtask

	task automatic run_phase(int n, bit hold, bit pause);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 && hold)
				hold_reqs++;
			if (i == n / 2 && pause)
				wait_results(0);
			if ($urandom_range(99) < 12)
				send_item(ACT_WRITE, 5'($urandom), 5'($urandom));
			else
				send_tick();
		end
	endtask

	initial begin
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// upper bits of the length word must be dropped
		set_config(16'd1, 16'd2, 16'd0, 16'd1, {10'h3FF, 6'd2});
		for (int i = 0; i < MAX_LETTERS_DEF; i++) begin
			case (i)
				0:       send_item(ACT_WRITE, 5'd16, 5'(i));
				1:       send_item(ACT_WRITE, 5'd20, 5'(i));
				31:      send_item(ACT_WRITE, 5'd31, 5'(i));
				default: send_item(ACT_WRITE, 5'($urandom), 5'(i));
			endcase
		end
		repeat (10)
			send_tick();
		// rewrite the letter being sent
		send_item(ACT_WRITE, 5'd4, 5'd0);
		repeat (8)
			send_tick();
		send_item(ACT_WRITE, 5'd0, 5'd31);
		repeat (4)
			send_tick();

		for (int r = 0; r < 3; r++) begin
			case (r)
				0: begin
					sender_idle_pct   = 7;
					receiver_idle_pct = 60;
				end
				1: begin
					sender_idle_pct   = 60;
					receiver_idle_pct = 7;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			for (int p = 0; p < 4; p++) begin
				wait_results(3);
				if (r == 0 && p == 0) begin
					set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd32);
					run_phase(140, 1'b0, 1'b0);
				end else if (r == 1 && p == 0) begin
					set_config(16'd65534, 16'd65534, 16'd65534, 16'd65534, 16'd63);
					run_phase(20, 1'b0, 1'b0);
				end else begin
					random_config();
					run_phase(90, r == 0 && p == 1, r == 1 && p == 2);
				end
			end
		end

		wait_results(3);
		set_config(16'd3, 16'd3, 16'd3, 16'd3, 16'd3);
		run_phase(30, 1'b0, 1'b0);

		wait_results(10);
		sb.check_empty();
		$display("Run covered %0d tick items and %0d letter writes over %0d register writes.",
			sb.ticks, sb.writes, cfg_count);
		$display("Results seen with LED lit: %0d, during the repeat pause: %0d.",
			sb.lit_seen, sb.pause_seen);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
